// ----- hw/rtl/nvs_pkg.sv -----
// shared types and constants for the nearest vertex search block
`timescale 1ns / 1ps

package nvs_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned AddrW       = $clog2(MaxVertices);
  localparam int unsigned CountW      = AddrW + 1;
  localparam int unsigned CoordW      = 24;
  localparam int unsigned DiffW       = CoordW + 1;
  localparam int unsigned DistW       = 2 * DiffW;
  localparam int unsigned VertexW     = 3 * CoordW;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e                      op;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] nearest_index;
    logic             matched;
    logic [DistW-1:0] distance_sq;
  } rsp_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vertex_t;

  // tag that travels with one scanned entry through the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [AddrW-1:0] idx;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [DistW-1:0] sq_sum;
  } dist_t;

endpackage

// ----- hw/rtl/nvs_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module nvs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/nvs_dist.sv -----
// three-stage squared euclidean distance pipeline
`timescale 1ns / 1ps

module nvs_dist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nvs_pkg::tag_t    tag_i,
  input  nvs_pkg::vertex_t query_i,
  input  nvs_pkg::vertex_t vertex_i,
  output nvs_pkg::dist_t   dist_o
);

  nvs_pkg::tag_t tag1_q, tag2_q, tag3_q;

  logic signed [nvs_pkg::DiffW-1:0] dx_q, dy_q, dz_q;
  logic signed [nvs_pkg::DistW-1:0] px_q, py_q, pz_q;
  logic        [nvs_pkg::DistW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1: per-axis difference, one extra bit
    dx_q  <= {query_i.x[nvs_pkg::CoordW-1], query_i.x} -
             {vertex_i.x[nvs_pkg::CoordW-1], vertex_i.x};
    dy_q  <= {query_i.y[nvs_pkg::CoordW-1], query_i.y} -
             {vertex_i.y[nvs_pkg::CoordW-1], vertex_i.y};
    dz_q  <= {query_i.z[nvs_pkg::CoordW-1], query_i.z} -
             {vertex_i.z[nvs_pkg::CoordW-1], vertex_i.z};
    // stage 2: squares, always non-negative
    px_q  <= dx_q * dx_q;
    py_q  <= dy_q * dy_q;
    pz_q  <= dz_q * dz_q;
    // stage 3: sum never exceeds three times the largest square
    sum_q <= nvs_pkg::DistW'(unsigned'(px_q)) + nvs_pkg::DistW'(unsigned'(py_q)) +
             nvs_pkg::DistW'(unsigned'(pz_q));
  end

  assign dist_o.tag    = tag3_q;
  assign dist_o.sq_sum = sum_q;

endmodule

// ----- hw/rtl/nearest_vertex_search_core.sv -----
// top level of the nearest vertex search block
`timescale 1ns / 1ps

// Nearest vertex search: keeps up to 1024 signed Q8.16 points in an on-chip
// memory. A request is taken when start_i is high and busy_o is low; its one
// result shows on rsp_o for a single cycle with done_o high and cannot be held
// off, so the receiver must take it then. Append, clear and an unused op code
// keep busy_o low and their result appears the cycle after the request, so
// these can be issued back to back. A query on a non-empty store holds busy_o
// high while it reads every stored vertex, one per cycle through the single
// memory read port, then a three-stage distance pipeline and a compare stage.
// A query on an empty store answers with the empty status and busy_o stays
// low. Ties go to the lowest index. The tolerance register may be written at
// any time the block is idle and resets to 1.

module nearest_vertex_search_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  nvs_pkg::req_t             req_i,
  output logic                      busy_o,
  output logic                      done_o,
  output nvs_pkg::rsp_t             rsp_o,
  input  logic                      cfg_we_i,
  input  logic [nvs_pkg::DistW-1:0] cfg_wdata_i
);

  // control state
  nvs_pkg::state_e                state_q, state_d;
  logic [nvs_pkg::CountW-1:0]     count_q, count_d;
  logic [nvs_pkg::CountW-1:0]     issue_q, issue_d;
  logic                           first_q, first_d;
  logic                           done_q, done_d;
  nvs_pkg::tag_t                  tag_q, tag_d;

  // payload
  nvs_pkg::vertex_t               qpt_q;
  logic [nvs_pkg::DistW-1:0]      best_q, best_d;
  logic [nvs_pkg::AddrW-1:0]      best_idx_q, best_idx_d;
  nvs_pkg::rsp_t                  rsp_q, rsp_d;
  logic [nvs_pkg::DistW-1:0]      tol_q;

  // memory port
  logic                           ram_we, ram_re;
  logic [nvs_pkg::AddrW-1:0]      ram_waddr, ram_raddr;
  nvs_pkg::vertex_t               ram_wdata, ram_rdata;

  nvs_pkg::dist_t                 scan_dist;
  nvs_pkg::vertex_t               req_pt;
  logic                           accept;
  logic                           scan_last;

  assign accept    = start_i && (state_q == nvs_pkg::S_IDLE);
  assign busy_o    = (state_q != nvs_pkg::S_IDLE);
  assign scan_last = ((issue_q + nvs_pkg::CountW'(1)) == count_q);

  assign req_pt.x = req_i.coord_x;
  assign req_pt.y = req_i.coord_y;
  assign req_pt.z = req_i.coord_z;

  // vertex store
  nvs_ram #(
    .Width (nvs_pkg::VertexW),
    .Depth (nvs_pkg::MaxVertices)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // tag_q lines up with the registered read data of the store
  nvs_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag_q),
    .query_i  (qpt_q),
    .vertex_i (ram_rdata),
    .dist_o   (scan_dist)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nvs_pkg::S_IDLE: begin
        if (accept && (req_i.op == nvs_pkg::OP_QUERY) && (count_q != '0)) begin
          state_d = nvs_pkg::S_SCAN;
        end
      end
      nvs_pkg::S_SCAN: begin
        if (scan_last) begin
          state_d = nvs_pkg::S_DRAIN;
        end
      end
      nvs_pkg::S_DRAIN: begin
        // last entry leaves the distance pipeline and is compared this cycle
        if (scan_dist.tag.valid && scan_dist.tag.last) begin
          state_d = nvs_pkg::S_FIN;
        end
      end
      nvs_pkg::S_FIN: begin
        state_d = nvs_pkg::S_IDLE;
      end
      default: begin
        state_d = nvs_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d    = count_q;
    issue_d    = issue_q;
    first_d    = first_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    tag_d      = '0;
    ram_we     = 1'b0;
    ram_waddr  = count_q[nvs_pkg::AddrW-1:0];
    ram_wdata  = req_pt;
    ram_re     = 1'b0;
    ram_raddr  = issue_q[nvs_pkg::AddrW-1:0];

    case (state_q)
      nvs_pkg::S_IDLE: begin
        if (accept) begin
          rsp_d  = '0;
          done_d = 1'b1;
          case (req_i.op)
            nvs_pkg::OP_APPEND: begin
              if (count_q >= nvs_pkg::CountW'(nvs_pkg::MaxVertices)) begin
                rsp_d.status = nvs_pkg::STAT_FULL;
              end else begin
                ram_we              = 1'b1;
                rsp_d.nearest_index = count_q[nvs_pkg::AddrW-1:0];
                count_d             = count_q + nvs_pkg::CountW'(1);
              end
            end
            nvs_pkg::OP_QUERY: begin
              if (count_q == '0) begin
                rsp_d.status = nvs_pkg::STAT_EMPTY;
              end else begin
                // result comes later from the scan
                done_d  = 1'b0;
                issue_d = '0;
                first_d = 1'b1;
              end
            end
            nvs_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
              // unused code: zero result, no state change
            end
          endcase
        end
      end
      nvs_pkg::S_SCAN: begin
        ram_re    = 1'b1;
        issue_d   = issue_q + nvs_pkg::CountW'(1);
        tag_d.valid = 1'b1;
        tag_d.last  = scan_last;
        tag_d.idx   = issue_q[nvs_pkg::AddrW-1:0];
      end
      nvs_pkg::S_FIN: begin
        done_d              = 1'b1;
        rsp_d.status        = nvs_pkg::STAT_OK;
        rsp_d.nearest_index = best_idx_q;
        rsp_d.matched       = (best_q < tol_q);
        rsp_d.distance_sq   = best_q;
      end
      default: begin
      end
    endcase

    // running minimum, strict compare keeps the lowest index on ties
    if (scan_dist.tag.valid) begin
      first_d = 1'b0;
      if (first_q || (scan_dist.sq_sum < best_q)) begin
        best_d     = scan_dist.sq_sum;
        best_idx_d = scan_dist.tag.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nvs_pkg::S_IDLE;
      count_q <= '0;
      issue_q <= '0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      tag_q   <= '0;
      tol_q   <= nvs_pkg::DistW'(1);
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      first_q <= first_d;
      done_q  <= done_d;
      tag_q   <= tag_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      qpt_q <= req_pt;
    end
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    rsp_q      <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  // fill level never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= nvs_pkg::CountW'(nvs_pkg::MaxVertices))
    else $error("vertex count beyond capacity");

  // store is written only between queries, so scan reads never race a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == nvs_pkg::S_IDLE) && !ram_re)
    else $error("store write during scan");

  // distance results arrive only while a query is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_dist.tag.valid |-> (state_q == nvs_pkg::S_SCAN || state_q == nvs_pkg::S_DRAIN))
    else $error("stray distance result");

  // finishing a query always delivers its result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nvs_pkg::S_FIN) |=> done_o && (rsp_o.status == nvs_pkg::STAT_OK))
    else $error("query finished without result");

  // no result strobe while a scan is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nvs_pkg::S_SCAN || state_q == nvs_pkg::S_DRAIN) |-> !done_d)
    else $error("result raised mid scan");
`endif

endmodule

// ----- sim/nvs_tb_pkg.sv -----
// scoreboard class with a mirror of the vertex store and the tolerance register
`timescale 1ns / 1ps

package nvs_tb_pkg;
  import nvs_pkg::*;

  class nvs_scoreboard;
    vertex_t          store_copy [MaxVertices];
    int unsigned      count_copy;
    logic [DistW-1:0] tol_copy;
    rsp_t             awaited_rsp [$];
    int unsigned      errors;
    int unsigned      n_append, n_full, n_query, n_empty, n_matched, n_clear, n_unused;

    function new();
      tol_copy = 1;
    endfunction

    function void set_tolerance(logic [DistW-1:0] value);
      tol_copy = value;
    endfunction

    // squared euclidean distance, exact in 64 bits at this coordinate width
    function logic [63:0] span_sq(vertex_t a, vertex_t b);
      longint dx, dy, dz;
      dx = longint'(a.x) - longint'(b.x);
      dy = longint'(a.y) - longint'(b.y);
      dz = longint'(a.z) - longint'(b.z);
      return dx * dx + dy * dy + dz * dz;
    endfunction

    // applies one request to the mirror and returns the result it must give
    function rsp_t nearest_result(req_t r);
      rsp_t        res;
      vertex_t     p;
      logic [63:0] best, cand;
      int unsigned best_i, i;
      res = '0;
      p.x = r.coord_x;
      p.y = r.coord_y;
      p.z = r.coord_z;
      case (r.op)
        OP_APPEND: begin
          n_append++;
          if (count_copy >= MaxVertices) begin
            res.status = STAT_FULL;
            n_full++;
          end else begin
            store_copy[count_copy] = p;
            res.nearest_index = AddrW'(count_copy);
            count_copy++;
          end
        end
        OP_QUERY: begin
          n_query++;
          if (count_copy == 0) begin
            res.status = STAT_EMPTY;
            n_empty++;
          end else begin
            best   = span_sq(p, store_copy[0]);
            best_i = 0;
            for (i = 1; i < count_copy; i++) begin
              cand = span_sq(p, store_copy[i]);
              if (cand < best) begin
                best   = cand;
                best_i = i;
              end
            end
            res.nearest_index = AddrW'(best_i);
            res.distance_sq   = best[DistW-1:0];
            res.matched       = (best < tol_copy);
            if (res.matched) n_matched++;
          end
        end
        OP_CLEAR: begin
          count_copy = 0;
          n_clear++;
        end
        default: n_unused++;
      endcase
      return res;
    endfunction

    function void note_request(req_t r);
      awaited_rsp.push_back(nearest_result(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited_rsp.size() == 0) begin
        $error("result with no request outstanding: status %0d index %0d",
               got.status, got.nearest_index);
        errors++;
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.nearest_index !== want.nearest_index) begin
        $error("nearest_index: expected %0d, got %0d", want.nearest_index, got.nearest_index);
        errors++;
      end
      if (got.matched !== want.matched) begin
        $error("matched: expected %0d, got %0d", want.matched, got.matched);
        errors++;
      end
      if (got.distance_sq !== want.distance_sq) begin
        $error("distance_sq: expected %0d, got %0d", want.distance_sq, got.distance_sq);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- sim/tb_top.sv -----
// top level testbench for the nearest vertex search block
`timescale 1ns / 1ps

module tb_top;
  import nvs_pkg::*;
  import nvs_tb_pkg::*;

  // op code the block must ignore
  localparam logic [1:0] OpUnused = 2'd3;

  localparam int CMax = (1 << (CoordW - 1)) - 1;
  localparam int CMin = -(1 << (CoordW - 1));
  // spread of the clustered coordinates, about four units either side
  localparam int Spread = 1 << 18;

  // largest tolerance the register is meant to hold
  localparam logic [63:0]      TolTop    = 64'd844424829468676;
  localparam logic [DistW-1:0] TolMax    = DistW'(TolTop);
  localparam logic [DistW-1:0] OneUnitSq = DistW'(64'd1 << 32);

  localparam int unsigned Phases        = 8;
  localparam int unsigned ItemsPerPhase = 70;
  // longest quiet stretch is a full-store query plus a sender gap
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned TailCycles    = 12;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             done;
  req_t             req;
  rsp_t             rsp;
  logic             cfg_we;
  logic [DistW-1:0] cfg_wdata;

  nvs_scoreboard sb;
  int unsigned   quiet_cycles = 0;
  int unsigned   n_tol_writes = 0;
  bit            calm_sender  = 1'b1;

  nearest_vertex_search_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .req_i       (req),
    .busy_o      (busy),
    .done_o      (done),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // results cannot be held off: take every strobed result at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && done) sb.check_response(rsp);
  end

  // watchdog on cycles where neither a request nor a result moves
  always @(posedge clk) begin
    if (!rst_n || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: nothing moved for %0d cycles", WatchdogLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic req_t make_req(op_e op, int x, int y, int z);
    req_t r;
    r.op      = op;
    r.coord_x = CoordW'(x);
    r.coord_y = CoordW'(y);
    r.coord_z = CoordW'(z);
    return r;
  endfunction

  // mix of full-range, corner and clustered coordinates
  function automatic int random_coord();
    case ($urandom_range(0, 7))
      0, 1: return int'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0: return CMin;
          1: return CMax;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return int'($urandom_range(0, 2 * Spread)) - Spread;
    endcase
  endfunction

  // a stored coordinate, exact half the time, else up to three lsbs either way
  function automatic int near_coord(logic signed [CoordW-1:0] c);
    int v;
    v = c;
    if ($urandom_range(0, 1)) return v;
    return v + int'($urandom_range(0, 6)) - 3;
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic issue(input req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.awaited_rsp.size() != 0) @(negedge clk);
  endtask

  // register writes only with the block idle
  task automatic set_tolerance(input logic [DistW-1:0] value);
    drain();
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_tolerance(value);
    n_tol_writes++;
  endtask

  // one random request, often aimed at a stored vertex so that matches and ties happen
  task automatic random_item(input int unsigned clear_pct);
    int unsigned pick, count;
    bit          aim;
    vertex_t     base;
    op_e         op;
    int          x, y, z;
    if (!calm_sender && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    if ($urandom_range(0, 49) == 0) drain();
    pick  = $urandom_range(0, 99);
    count = sb.count_copy;
    x = random_coord();
    y = random_coord();
    z = random_coord();
    if (count != 0) base = sb.store_copy[$urandom_range(0, count - 1)];
    if (pick < clear_pct) begin
      op  = OP_CLEAR;
      aim = 1'b0;
    end else if (pick < clear_pct + 3) begin
      op  = op_e'(OpUnused);
      aim = 1'b0;
    end else if (pick < 55) begin
      op  = OP_APPEND;
      aim = ($urandom_range(0, 9) < 3);
    end else begin
      op  = OP_QUERY;
      aim = $urandom_range(0, 1);
    end
    if (aim && count != 0) begin
      x = near_coord(base.x);
      y = near_coord(base.y);
      z = near_coord(base.z);
    end
    issue(make_req(op, x, y, z));
  endtask

  initial begin
    int unsigned phase, k;
    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, back to back, tolerance still at its reset value of 1
    issue(make_req(OP_QUERY, 0, 0, 0));                    // empty store
    issue(make_req(op_e'(OpUnused), CMax, CMin, CMax));    // ignored op code
    issue(make_req(OP_APPEND, CMax, CMax, CMax));
    issue(make_req(OP_APPEND, CMin, CMin, CMin));
    issue(make_req(OP_APPEND, 0, 0, 0));
    issue(make_req(OP_QUERY, CMin, CMin, CMin));           // exact hit, below tolerance
    issue(make_req(OP_QUERY, CMax, CMax, CMax));
    issue(make_req(OP_QUERY, 0, 0, 1));                    // distance equal to tolerance
    issue(make_req(OP_CLEAR, 0, 0, 0));
    issue(make_req(OP_QUERY, 0, 0, 0));                    // empty again after clear
    issue(make_req(OP_APPEND, 1, 0, 0));
    issue(make_req(OP_APPEND, -1, 0, 0));
    issue(make_req(OP_APPEND, 0, -1, 0));
    issue(make_req(OP_QUERY, 0, 0, 0));                    // three-way tie, lowest wins
    issue(make_req(OP_APPEND, 1, 0, 0));                   // duplicate vertex
    issue(make_req(OP_QUERY, 1, 0, 0));                    // tie between duplicates
    issue(make_req(OP_CLEAR, 0, 0, 0));
    issue(make_req(OP_APPEND, CMax, CMin, CMax));
    issue(make_req(OP_QUERY, CMin, CMax, CMin));           // largest possible distance
    issue(make_req(OP_QUERY, CMax, CMax, CMax));
    issue(make_req(op_e'(OpUnused), 0, 0, 0));             // state must survive it
    issue(make_req(OP_QUERY, 0, 0, 0));
    issue(make_req(OP_CLEAR, 0, 0, 0));

    // random phases, each setting a tolerance first; phases 3 and 7 skip the random sender gaps
    for (phase = 0; phase < Phases; phase++) begin
      case (phase % 6)
        0: set_tolerance(TolMax);
        1: set_tolerance('0);
        2: set_tolerance(OneUnitSq);
        3: set_tolerance(DistW'({$urandom, $urandom} % (TolTop + 64'd1)));
        4: set_tolerance(DistW'($urandom_range(1, 1 << 20)));
        default: set_tolerance(DistW'(1));
      endcase
      calm_sender = (phase == 3) || (phase == Phases - 1);
      for (k = 0; k < ItemsPerPhase; k++) begin
        random_item((phase % 2 == 0) ? 2 : 6);
      end
    end

    // closing requests back to back on whatever the store holds
    calm_sender = 1'b1;
    issue(make_req(OP_QUERY, CMax, CMin, CMax));
    issue(make_req(op_e'(OpUnused), random_coord(), random_coord(), random_coord()));
    issue(make_req(OP_CLEAR, 0, 0, 0));
    issue(make_req(OP_QUERY, 0, 0, 0));

    drain();
    repeat (TailCycles) @(negedge clk);
    if (sb.awaited_rsp.size() != 0) begin
      $error("%0d results never arrived", sb.awaited_rsp.size());
      sb.errors++;
    end

    $display("covered: %0d appends (%0d into a full store), %0d clears, %0d unused op codes",
             sb.n_append, sb.n_full, sb.n_clear, sb.n_unused);
    $display("covered: %0d queries (%0d on an empty store, %0d matched), %0d tolerance writes",
             sb.n_query, sb.n_empty, sb.n_matched, n_tol_writes);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/nvs_pkg.sv
hw/rtl/nvs_ram.sv
hw/rtl/nvs_dist.sv
hw/rtl/nearest_vertex_search_core.sv
sim/nvs_tb_pkg.sv
sim/tb_top.sv
